// ===== rtl/mlwe_dt_pkg.sv =====
// Shared types and constants for the module-LWE decryption block.
// No dependencies; used by mlwe_dt_cell and mlwe_decrypt_threshold.
`default_nettype none

package mlwe_dt_pkg;

  localparam int COEFF_W          = 16;
  localparam int CELLS            = COEFF_W;
  localparam int DEF_RING_DEGREE  = 256;
  localparam int DEF_MODULE_RANK  = 3;
  localparam logic [COEFF_W-1:0] MOD_Q_RESET = 16'd3329;
  localparam logic [COEFF_W-1:0] MOD_Q_MIN   = 16'd3;

  typedef enum logic [1:0] {
    REQ_SK   = 2'd0,
    REQ_U    = 2'd1,
    REQ_V    = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  // Operands travelling down the row of modular cells.
  typedef struct packed {
    logic               vld;
    logic [COEFF_W-1:0] ra;  // running (u * s) mod q
    logic [COEFF_W-1:0] rb;  // running acc mod q
    logic [COEFF_W-1:0] u;
    logic [COEFF_W-1:0] s;   // key bits, MSB consumed first
    logic [COEFF_W-1:0] a;   // accumulator bits, MSB consumed first
  } lane_t;

endpackage

`default_nettype wire

// ===== rtl/mlwe_dt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mlwe_dt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mlwe_dt_cell.sv =====
// One step of bit-serial modular multiplication and reduction.
// Depends on mlwe_dt_pkg.
`default_nettype none

module mlwe_dt_cell import mlwe_dt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COEFF_W-1:0] q_i,
  input  wire lane_t              lane_i,
  output      lane_t              lane_o
);

  logic [COEFF_W+1:0] q_x, ra_sum, ra_s1, ra_s2, rb_sum, rb_s1;
  logic               vld_q;
  logic [COEFF_W-1:0] ra_q, rb_q, u_q, s_q, a_q;

  // Doubling plus one partial product stays below 3q, so two subtracts suffice.
  always_comb begin
    q_x    = {2'b00, q_i};
    ra_sum = {1'b0, lane_i.ra, 1'b0} +
             (lane_i.s[COEFF_W-1] ? {2'b00, lane_i.u} : '0);
    ra_s1  = (ra_sum >= q_x) ? ra_sum - q_x : ra_sum;
    ra_s2  = (ra_s1 >= q_x) ? ra_s1 - q_x : ra_s1;
    rb_sum = {1'b0, lane_i.rb, 1'b0} + {{(COEFF_W+1){1'b0}}, lane_i.a[COEFF_W-1]};
    rb_s1  = (rb_sum >= q_x) ? rb_sum - q_x : rb_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= lane_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_s2[COEFF_W-1:0];
    rb_q <= rb_s1[COEFF_W-1:0];
    u_q  <= lane_i.u;
    s_q  <= {lane_i.s[COEFF_W-2:0], 1'b0};
    a_q  <= {lane_i.a[COEFF_W-2:0], 1'b0};
  end

  always_comb begin
    lane_o.vld = vld_q;
    lane_o.ra  = ra_q;
    lane_o.rb  = rb_q;
    lane_o.u   = u_q;
    lane_o.s   = s_q;
    lane_o.a   = a_q;
  end

endmodule

`default_nettype wire

// ===== rtl/mlwe_decrypt_threshold.sv =====
// A u coefficient keeps the block busy while it sweeps the whole accumulator,
// a v coefficient gives its message bit once it has passed the cell row, and
// rejected or ignored items never enter the row. One item is in work at a time;
// the N-coefficient sweep over the accumulator and the 16-cell row set its busy time.
// Reset: rst_ni is asynchronous, active low; it sets q to 3329 and marks
// the accumulator as all zero. The secret-key store is not cleared.
`default_nettype none

module mlwe_decrypt_threshold import mlwe_dt_pkg::*; #(
  parameter int RING_DEGREE = DEF_RING_DEGREE,
  parameter int MODULE_RANK = DEF_MODULE_RANK
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: modulus q.
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Input transactions.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tdata: poly_index[1:0], coeff_index[11:2], coeff_value[27:12], zero fill.
  input  wire logic [31:0] s_axis_tdata,
  // tuser: req_type[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  // Result transactions.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: msg_bit[0], bit_index[10:1], zero fill.
  output      logic [15:0] m_axis_tdata,
  output      logic        m_axis_tlast,
  // tuser: status[1:0].
  output      logic [1:0]  m_axis_tuser
);

  localparam int IDX_W    = $clog2(RING_DEGREE);
  localparam int SK_DEPTH = MODULE_RANK * RING_DEGREE;
  localparam int SK_W     = $clog2(SK_DEPTH);
  localparam int POS_W    = $clog2(SK_DEPTH + 1);

  // Control that travels beside the cell row.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               is_v;
    logic               add;
    logic [IDX_W-1:0]   m;
    logic [COEFF_W-1:0] vv;
  } meta_t;

  // Input field decode.
  logic [1:0]         in_type;
  logic [1:0]         in_poly;
  logic [9:0]         in_idx;
  logic [COEFF_W-1:0] in_val;
  logic               accept;

  assign in_type = s_axis_tuser;
  assign in_poly = s_axis_tdata[1:0];
  assign in_idx  = s_axis_tdata[11:2];
  assign in_val  = s_axis_tdata[27:12];

  // Registers.
  state_e              state_q, state_d;
  logic [COEFF_W-1:0]  mod_q_q;
  logic [POS_W-1:0]    upos_q;
  logic [RING_DEGREE-1:0] acc_valid_q;
  logic [SK_W-1:0]     sbase_q;
  logic [IDX_W-1:0]    k_q, m_q;
  logic                add_q, isv_q;
  logic [COEFF_W-1:0]  u_q, vv_q;
  logic                iss_vld_q;
  meta_t               iss_meta_q;
  meta_t               iss_q;
  logic                acc_vld_rd_q;
  meta_t               meta_q [CELLS];
  logic                out_valid_q;
  logic                out_bit_q, out_last_q;
  logic [9:0]          out_idx_q;
  logic [1:0]          out_status_q;

  // Request checks.
  logic             val_bad, poly_ok, idx_ok, restart, u_in_order;
  logic [POS_W-1:0] pos_in, base_in;

  always_comb begin
    val_bad    = in_val >= mod_q_q;
    poly_ok    = {1'b0, in_poly} < 3'(MODULE_RANK);
    idx_ok     = {1'b0, in_idx} < 11'(RING_DEGREE);
    base_in    = POS_W'(in_poly) * POS_W'(RING_DEGREE);
    pos_in     = base_in + POS_W'(in_idx);
    restart    = (in_poly == 2'd0) && (in_idx == 10'd0);
    u_in_order = poly_ok && idx_ok && (pos_in == upos_q);
  end

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic start_u, start_v, sk_we, err_range, err_order;

  always_comb begin
    start_u   = 1'b0;
    start_v   = 1'b0;
    sk_we     = 1'b0;
    err_range = 1'b0;
    err_order = 1'b0;
    if (accept && (in_type != REQ_NONE)) begin
      if (val_bad) begin
        err_range = 1'b1;
      end else begin
        case (in_type)
          REQ_SK: sk_we = poly_ok && idx_ok;
          REQ_U: begin
            if (restart || u_in_order) begin
              start_u = 1'b1;
            end else begin
              err_order = 1'b1;
            end
          end
          REQ_V: start_v = idx_ok;
          default: ;
        endcase
      end
    end
  end

  // Secret-key store.
  logic [COEFF_W-1:0] sk_rdata;

  mlwe_dt_ram #(.WIDTH(COEFF_W), .DEPTH(SK_DEPTH)) u_sk_ram (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (pos_in[SK_W-1:0]),
    .wdata_i (in_val),
    .raddr_i (sbase_q + SK_W'(k_q)),
    .rdata_o (sk_rdata)
  );

  // Accumulator store; entries not yet written since the last restart read as zero.
  logic               acc_we;
  logic [COEFF_W-1:0] acc_wdata, acc_rdata;
  meta_t              tail;

  mlwe_dt_ram #(.WIDTH(COEFF_W), .DEPTH(RING_DEGREE)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (tail.m),
    .wdata_i (acc_wdata),
    .raddr_i (m_q),
    .rdata_o (acc_rdata)
  );

  // Issue sequencer: one coefficient per cycle while running.
  logic issue, issue_last;

  assign issue      = (state_q == S_RUN);
  assign issue_last = isv_q || (k_q == IDX_W'(RING_DEGREE - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_u || start_v) state_d = S_RUN;
      S_RUN:   if (issue_last) state_d = S_DRAIN;
      S_DRAIN: if (tail.vld && tail.last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mod_q_q     <= MOD_Q_RESET;
      upos_q      <= '0;
      acc_valid_q <= '0;
      iss_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_vld_q <= issue;
      if (cfg_we_i) begin
        mod_q_q <= (cfg_wdata_i < MOD_Q_MIN) ? MOD_Q_MIN : cfg_wdata_i;
      end
      if (start_u) begin
        if (restart) begin
          upos_q      <= POS_W'(1);
          acc_valid_q <= '0;
        end else begin
          upos_q <= upos_q + POS_W'(1);
        end
      end
      if (acc_we) begin
        acc_valid_q[tail.m] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_u || start_v) begin
      // A v item does not use the key, so point the read at row zero.
      sbase_q <= start_v ? '0 : base_in[SK_W-1:0];
      k_q     <= '0;
      m_q     <= in_idx[IDX_W-1:0];
      add_q   <= 1'b0;
      isv_q   <= start_v;
      u_q     <= start_v ? '0 : in_val;
      vv_q    <= in_val;
    end else if (issue) begin
      k_q <= k_q + IDX_W'(1);
      if (m_q == IDX_W'(RING_DEGREE - 1)) begin
        m_q   <= '0;
        add_q <= 1'b1;
      end else begin
        m_q <= m_q + IDX_W'(1);
      end
    end
    iss_meta_q.vld  <= issue;
    iss_meta_q.last <= issue_last;
    iss_meta_q.is_v <= isv_q;
    iss_meta_q.add  <= add_q;
    iss_meta_q.m    <= m_q;
    iss_meta_q.vv   <= vv_q;
    acc_vld_rd_q    <= acc_valid_q[m_q];
  end

  always_comb begin
    iss_q     = iss_meta_q;
    iss_q.vld = iss_vld_q;
  end

  // Row of modular cells.
  lane_t lane [CELLS+1];

  always_comb begin
    lane[0].vld = iss_q.vld;
    lane[0].ra  = '0;
    lane[0].rb  = '0;
    lane[0].u   = u_q;
    lane[0].s   = sk_rdata;
    lane[0].a   = acc_vld_rd_q ? acc_rdata : '0;
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    mlwe_dt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .q_i    (mod_q_q),
      .lane_i (lane[g]),
      .lane_o (lane[g+1])
    );

    always_ff @(posedge clk_i) begin
      meta_q[g] <= (g == 0) ? iss_q : meta_q[(g == 0) ? 0 : g-1];
    end
  end

  always_comb begin
    tail     = meta_q[CELLS-1];
    tail.vld = lane[CELLS].vld;
  end

  // Final combine: negacyclic update of the accumulator, or threshold decode.
  logic [COEFF_W:0]   q_x, upd_sum, upd_red, c_sum, c_red;
  logic [COEFF_W-1:0] thr, c_val;
  logic               msg;

  always_comb begin
    q_x     = {1'b0, mod_q_q};
    upd_sum = tail.add ? {1'b0, lane[CELLS].rb} + {1'b0, lane[CELLS].ra}
                       : {1'b0, lane[CELLS].rb} + q_x - {1'b0, lane[CELLS].ra};
    upd_red = (upd_sum >= q_x) ? upd_sum - q_x : upd_sum;
    acc_wdata = upd_red[COEFF_W-1:0];
    acc_we    = tail.vld && !tail.is_v;
    c_sum   = {1'b0, tail.vv} + {1'b0, lane[CELLS].rb};
    c_red   = (c_sum >= q_x) ? c_sum - q_x : c_sum;
    c_val   = c_red[COEFF_W-1:0];
    thr     = mod_q_q >> 2;
    msg     = (c_val > thr) && (c_val < (mod_q_q - thr));
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (err_range || err_order || (tail.vld && tail.is_v)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_range || err_order) begin
      out_bit_q    <= 1'b0;
      out_idx_q    <= in_idx;
      out_last_q   <= 1'b0;
      out_status_q <= err_range ? ST_RANGE : ST_ORDER;
    end else if (tail.vld && tail.is_v) begin
      out_bit_q    <= msg;
      out_idx_q    <= 10'(tail.m);
      out_last_q   <= (tail.m == IDX_W'(RING_DEGREE - 1));
      out_status_q <= ST_OK;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_idx_q, out_bit_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

  // Checks.
  a_mod_q_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_q_q >= MOD_Q_MIN) else $error("modulus below minimum");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> (state_q != S_IDLE)) else $error("accumulator written while idle");

  a_upos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upos_q <= POS_W'(SK_DEPTH)) else $error("u position past end");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.vld && tail.last) |=> (state_q == S_IDLE)) else $error("sweep did not end");

endmodule

`default_nettype wire
